// ===== rtl/voxel_edge_neighbour_label_assert.svh =====
// Assertion helpers for the voxel edge labeller RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef VOXEL_EDGE_NEIGHBOUR_LABEL_ASSERT_SVH
`define VOXEL_EDGE_NEIGHBOUR_LABEL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge
`define VEDGE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define VEDGE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VEDGE_ASSERT(lbl, prop, msg)
`define VEDGE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/vedge_pkg.sv =====
`timescale 1ns / 1ps
package vedge_pkg;

	localparam int FIELD_W = 16;

	// configuration register indexes
	localparam logic [2:0] REG_EPSILON     = 3'd0;
	localparam logic [2:0] REG_SIZE_X      = 3'd1;
	localparam logic [2:0] REG_SIZE_Y      = 3'd2;
	localparam logic [2:0] REG_SIZE_Z      = 3'd3;
	localparam logic [2:0] REG_LABEL_MODE  = 3'd4;
	localparam logic [2:0] REG_MIN_SIMILAR = 3'd5;

	// register reset values
	localparam logic [15:0] RST_EPSILON     = 16'd0;
	localparam logic [8:0]  RST_SIZE_X      = 9'd256;
	localparam logic [8:0]  RST_SIZE_Y      = 9'd256;
	localparam logic [12:0] RST_SIZE_Z      = 13'd256;
	localparam logic        RST_LABEL_MODE  = 1'b0;
	localparam logic [4:0]  RST_MIN_SIMILAR = 5'd23;

	localparam logic [12:0] DEPTH_LIMIT = 13'd4096;

	localparam logic MODE_NEIGHBOUR = 1'b0;
	localparam logic MODE_BASIC     = 1'b1;

	// output queue
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int INFL_W     = $clog2(OUTQ_DEPTH + 1);

	typedef struct packed {
		logic        label_valid;
		logic        edge_label;
		logic [7:0]  out_x;
		logic [7:0]  out_y;
		logic [11:0] out_z;
	} result_t;

	typedef struct packed {
		logic    nbr;   // label decided by the neighbour count
		result_t res;
	} meta_t;

endpackage

// ===== rtl/vedge_if.sv =====
`timescale 1ns / 1ps
interface vedge_in_if;
	logic                         valid;
	logic                         ready;
	logic [vedge_pkg::FIELD_W-1:0] voxel_value;
	logic [vedge_pkg::FIELD_W-1:0] gradient_magnitude;

	modport source (output valid, voxel_value, gradient_magnitude, input ready);
	modport sink   (input valid, voxel_value, gradient_magnitude, output ready);
endinterface

interface vedge_out_if;
	logic        valid;
	logic        ready;
	logic        label_valid;
	logic        edge_label;
	logic [7:0]  out_x;
	logic [7:0]  out_y;
	logic [11:0] out_z;

	modport source (output valid, label_valid, edge_label, out_x, out_y, out_z, input ready);
	modport sink   (input valid, label_valid, edge_label, out_x, out_y, out_z, output ready);
endinterface

// ===== rtl/vedge_window.sv =====
`timescale 1ns / 1ps
module vedge_window #(
	parameter int SB          = 16,
	parameter int PLANE_DEPTH = 65536,
	parameter int ROW_DEPTH   = 256,
	localparam int PAW        = $clog2(PLANE_DEPTH),
	localparam int RAW        = $clog2(ROW_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [PAW-1:0]       plane_addr,
	input  logic [RAW-1:0]       row_addr,
	input  logic [SB-1:0]        sample,
	output logic [26:0][SB-1:0]  win
);

	// plane entry: [0] one plane back, [1] two planes back
	// row entry: per plane stream k, [2k] one row back, [2k+1] two rows back
	logic [1:0][SB-1:0] plane_mem [PLANE_DEPTH];
	logic [5:0][SB-1:0] row_mem   [ROW_DEPTH];

	logic               v_s1;
	logic [PAW-1:0]     pa_s1;
	logic [RAW-1:0]     ra_s1;
	logic [SB-1:0]      sample_s1;
	logic [1:0][SB-1:0] plane_rd_s1;
	logic [5:0][SB-1:0] row_rd_s1;

	logic [2:0][SB-1:0]      st0;
	logic [5:0][SB-1:0]      row_wr;
	logic [2:0][2:0][SB-1:0] col;
	logic [26:0][SB-1:0]     win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pa_s1     <= plane_addr;
			ra_s1     <= row_addr;
			sample_s1 <= sample;
		end
	end

	// Read on accept, write back in the following cycle. The same entry is touched on
	// consecutive beats only for a width or plane of one voxel, where no
	// voxel is interior and the stale data is never used.
	always_ff @(posedge clk) begin
		if (acc) begin
			plane_rd_s1 <= plane_mem[plane_addr];
			row_rd_s1   <= row_mem[row_addr];
		end
		if (v_s1) begin
			plane_mem[pa_s1] <= {plane_rd_s1[0], sample_s1};
			row_mem[ra_s1]   <= row_wr;
		end
	end

	always_comb begin
		st0[0] = sample_s1;
		st0[1] = plane_rd_s1[0];
		st0[2] = plane_rd_s1[1];
		for (int k = 0; k < 3; k++) begin
			row_wr[2*k]   = st0[k];
			row_wr[2*k+1] = row_rd_s1[2*k];
			col[k][0]     = st0[k];
			col[k][1]     = row_rd_s1[2*k];
			col[k][2]     = row_rd_s1[2*k+1];
		end
	end

	// 3x3x3 window, index k*9 + j*3 + i, i = 0 newest; centre at 13
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k*9+j*3+2] <= win_q[k*9+j*3+1];
					win_q[k*9+j*3+1] <= win_q[k*9+j*3];
					win_q[k*9+j*3]   <= col[k][j];
				end
			end
		end
	end

	assign win = win_q;

endmodule

// ===== rtl/vedge_outq.sv =====
`timescale 1ns / 1ps
module vedge_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  vedge_pkg::result_t push_data,
	input  logic               pop,
	output vedge_pkg::result_t head,
	output logic               not_empty
);

	vedge_pkg::result_t                q_mem [vedge_pkg::OUTQ_DEPTH];
	logic [vedge_pkg::OUTQ_AW-1:0]     wptr_q;
	logic [vedge_pkg::OUTQ_AW-1:0]     rptr_q;
	logic [vedge_pkg::INFL_W-1:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wptr_q] <= push_data;
	end

	assign head      = q_mem[rptr_q];
	assign not_empty = (count_q != '0);

endmodule

// ===== rtl/voxel_edge_neighbour_label.sv =====
`timescale 1ns / 1ps
// Voxel edge/inner labeller.
// voxel (sink): one voxel per beat, raster order, x fastest; voxel_value and
//   gradient_magnitude, low SAMPLE_BITS bits used.
// label (source): exactly one beat per accepted voxel, in order. In neighbour
//   mode, label_valid is 0 while the neighbour window is still filling.
// cfg_we/cfg_index/cfg_data: register writes, only while the block is idle.
//   Writing a size or label_mode restarts the volume at (0,0,0).
// Neighbour mode: the label of a voxel leaves with the input beat that comes
//   1 + size_x + size_x*size_y beats after it; boundary voxels are inner.
// Basic mode: the label belongs to the voxel of the same beat.
// Path: a label passes stages s1, s2 and s3 into the output queue.
// Throughput: one voxel per cycle while ready is high, set by one
//   read-modify-write per voxel on both line memories (plane and row lines).
// Stall: up to 8 beats may be in flight or queued; when the queue is
//   committed, ready drops until label beats are taken.
// Reset: registers return to their defaults, the window clears and the
//   volume position returns to (0,0,0); line memories are not cleared.
`include "voxel_edge_neighbour_label_assert.svh"
module voxel_edge_neighbour_label #(
	parameter int MAX_X       = 256,
	parameter int MAX_Y       = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	vedge_in_if.sink          voxel,
	vedge_out_if.source       label,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	// x and y size registers are 9 bits wide, so those sizes never exceed 511
	localparam int EFF_X = (MAX_X < 511) ? MAX_X : 511;
	localparam int EFF_Y = (MAX_Y < 511) ? MAX_Y : 511;
	localparam int XW    = $clog2(EFF_X);
	localparam int YW    = $clog2(EFF_Y);
	localparam int XS    = $clog2(EFF_X + 1);
	localparam int YS    = $clog2(EFF_Y + 1);
	localparam int PD    = EFF_X * EFF_Y;
	localparam int PAW   = $clog2(PD);
	localparam int DW    = $clog2(2 + EFF_X + PD);
	localparam int SB    = SAMPLE_BITS;

	// ---------------- configuration registers
	logic [15:0] eps_q;
	logic [8:0]  size_x_q;
	logic [8:0]  size_y_q;
	logic [12:0] size_z_q;
	logic        mode_q;
	logic [4:0]  min_sim_q;
	logic        restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q     <= vedge_pkg::RST_EPSILON;
			size_x_q  <= vedge_pkg::RST_SIZE_X;
			size_y_q  <= vedge_pkg::RST_SIZE_Y;
			size_z_q  <= vedge_pkg::RST_SIZE_Z;
			mode_q    <= vedge_pkg::RST_LABEL_MODE;
			min_sim_q <= vedge_pkg::RST_MIN_SIMILAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vedge_pkg::REG_EPSILON:     eps_q     <= cfg_data;
				vedge_pkg::REG_SIZE_X:      size_x_q  <= cfg_data[8:0];
				vedge_pkg::REG_SIZE_Y:      size_y_q  <= cfg_data[8:0];
				vedge_pkg::REG_SIZE_Z:      size_z_q  <= cfg_data[12:0];
				vedge_pkg::REG_LABEL_MODE:  mode_q    <= cfg_data[0];
				vedge_pkg::REG_MIN_SIMILAR: min_sim_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == vedge_pkg::REG_SIZE_X ||
		cfg_index == vedge_pkg::REG_SIZE_Y || cfg_index == vedge_pkg::REG_SIZE_Z ||
		cfg_index == vedge_pkg::REG_LABEL_MODE);

	// effective sizes: 0 acts as 1, large values clip
	logic [XS-1:0] sx;
	logic [YS-1:0] sy;
	logic [12:0]   sz;
	logic [DW-1:0] delay_c;

	always_comb begin
		if (size_x_q == '0)                sx = XS'(1);
		else if (size_x_q > 9'(EFF_X))     sx = XS'(EFF_X);
		else                               sx = XS'(size_x_q);
		if (size_y_q == '0)                sy = YS'(1);
		else if (size_y_q > 9'(EFF_Y))     sy = YS'(EFF_Y);
		else                               sy = YS'(size_y_q);
		if (size_z_q == '0)                sz = 13'd1;
		else if (size_z_q > vedge_pkg::DEPTH_LIMIT) sz = vedge_pkg::DEPTH_LIMIT;
		else                               sz = size_z_q;
		// beats between a voxel and the beat that completes its window
		delay_c = DW'(1) + DW'(sx) + DW'(sx * sy);
	end

	// ---------------- stream position and window centre
	logic [XW-1:0]  pos_x_q, cen_x_q;
	logic [YW-1:0]  pos_y_q, cen_y_q;
	logic [11:0]    pos_z_q, cen_z_q;
	logic [PAW-1:0] plane_addr_q;
	logic [DW-1:0]  fill_q;
	logic           acc;
	logic           pop;
	logic           last_x, last_y, last_z;
	logic           filled;
	logic           cen_last_x, cen_last_y;
	logic           interior;
	logic [SB-1:0]  sample;
	logic [SB-1:0]  grad;
	vedge_pkg::meta_t meta_c;

	logic [vedge_pkg::INFL_W-1:0] inflight_q;

	assign voxel.ready = (inflight_q < vedge_pkg::INFL_W'(vedge_pkg::OUTQ_DEPTH));
	assign acc         = voxel.valid && voxel.ready;
	assign pop         = label.valid && label.ready;
	assign sample      = voxel.voxel_value[SB-1:0];
	assign grad        = voxel.gradient_magnitude[SB-1:0];

	assign last_x     = (pos_x_q == XW'(sx - 1'b1));
	assign last_y     = (pos_y_q == YW'(sy - 1'b1));
	assign last_z     = (pos_z_q == 12'(sz - 1'b1));
	assign cen_last_x = (cen_x_q == XW'(sx - 1'b1));
	assign cen_last_y = (cen_y_q == YW'(sy - 1'b1));
	assign filled     = (fill_q >= delay_c);
	assign interior   = (cen_x_q != '0) && !cen_last_x && (cen_y_q != '0) && !cen_last_y &&
		(cen_z_q != '0) && (cen_z_q != 12'(sz - 1'b1));

	// per-beat label info decided at accept time
	always_comb begin
		meta_c = '0;
		if (mode_q == vedge_pkg::MODE_BASIC) begin
			meta_c.res.label_valid = 1'b1;
			meta_c.res.edge_label  = (16'(grad) > eps_q);
			meta_c.res.out_x       = 8'(pos_x_q);
			meta_c.res.out_y       = 8'(pos_y_q);
			meta_c.res.out_z       = pos_z_q;
		end else if (filled) begin
			meta_c.nbr             = interior;
			meta_c.res.label_valid = 1'b1;
			meta_c.res.out_x       = 8'(cen_x_q);
			meta_c.res.out_y       = 8'(cen_y_q);
			meta_c.res.out_z       = cen_z_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pos_z_q      <= '0;
			cen_x_q      <= '0;
			cen_y_q      <= '0;
			cen_z_q      <= '0;
			plane_addr_q <= '0;
			fill_q       <= '0;
		end else if (restart || (acc && last_x && last_y && last_z)) begin
			// new volume; trailing labels of the old one are dropped
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pos_z_q      <= '0;
			cen_x_q      <= '0;
			cen_y_q      <= '0;
			cen_z_q      <= '0;
			plane_addr_q <= '0;
			fill_q       <= '0;
		end else if (acc) begin
			if (last_x) begin
				pos_x_q <= '0;
				if (last_y) begin
					pos_y_q <= '0;
					pos_z_q <= pos_z_q + 1'b1;
				end else begin
					pos_y_q <= pos_y_q + 1'b1;
				end
			end else begin
				pos_x_q <= pos_x_q + 1'b1;
			end
			// plane line address = y*sx + x, wraps at plane end
			if (last_x && last_y) plane_addr_q <= '0;
			else                  plane_addr_q <= plane_addr_q + 1'b1;
			if (!filled) fill_q <= fill_q + 1'b1;
			if (mode_q == vedge_pkg::MODE_NEIGHBOUR && filled) begin
				if (cen_last_x) begin
					cen_x_q <= '0;
					if (cen_last_y) begin
						cen_y_q <= '0;
						cen_z_q <= cen_z_q + 1'b1;
					end else begin
						cen_y_q <= cen_y_q + 1'b1;
					end
				end else begin
					cen_x_q <= cen_x_q + 1'b1;
				end
			end
		end
	end

	// ---------------- line memories and window
	logic [26:0][SB-1:0] win;

	vedge_window #(
		.SB          (SB),
		.PLANE_DEPTH (PD),
		.ROW_DEPTH   (EFF_X)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.plane_addr (plane_addr_q),
		.row_addr   (pos_x_q),
		.sample     (sample),
		.win        (win)
	);

	// ---------------- classification pipeline
	logic             v_s1, v_s2, v_s3;
	vedge_pkg::meta_t meta_s1, meta_s2, meta_s3;
	logic [8:0][1:0]  rowcnt_c, rowcnt_s3;
	logic [4:0]       total_c;
	vedge_pkg::result_t res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)  meta_s1 <= meta_c;
		if (v_s1) meta_s2 <= meta_s1;
		if (v_s2) begin
			meta_s3   <= meta_s2;
			rowcnt_s3 <= rowcnt_c;
		end
	end

	// s2: similar-neighbour count per window row (three taps, centre skipped)
	always_comb begin
		logic [SB-1:0] diff;
		for (int r = 0; r < 9; r++) begin
			rowcnt_c[r] = '0;
			for (int i = 0; i < 3; i++) begin
				if (win[r*3+i] > win[13]) diff = win[r*3+i] - win[13];
				else                      diff = win[13] - win[r*3+i];
				if ((r*3 + i) != 13 && 16'(diff) <= eps_q)
					rowcnt_c[r] = rowcnt_c[r] + 1'b1;
			end
		end
	end

	// s3: total and threshold
	always_comb begin
		total_c = '0;
		for (int r = 0; r < 9; r++) total_c = total_c + 5'(rowcnt_s3[r]);
		res_c = meta_s3.res;
		if (meta_s3.nbr) res_c.edge_label = (total_c < min_sim_q);
	end

	// ---------------- output queue and credit count
	vedge_pkg::result_t head;
	logic               not_empty;

	vedge_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (res_c),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	// beats accepted and not yet delivered; keeps the queue from overflowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			unique case ({acc, pop})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	assign label.valid       = not_empty;
	assign label.label_valid = head.label_valid;
	assign label.edge_label  = head.edge_label;
	assign label.out_x       = head.out_x;
	assign label.out_y       = head.out_y;
	assign label.out_z       = head.out_z;

	// ---------------- checks
	`VEDGE_ASSERT(a_credit_bound, inflight_q <= vedge_pkg::INFL_W'(vedge_pkg::OUTQ_DEPTH), "in-flight count above queue depth")
	`VEDGE_ASSERT_NEXT(a_accept_enters, acc, v_s1, "accepted beat did not enter the pipeline")
	`VEDGE_ASSERT(a_pop_has_credit, !label.valid || inflight_q != '0, "label beat without an accepted voxel")
	`VEDGE_ASSERT(a_pos_in_range, XS'(pos_x_q) < sx && YS'(pos_y_q) < sy, "stream position outside volume")

endmodule
